FILE: src/mscm_pkg.sv
// Shared constants and types of the key matrix scanner.
package mscm_pkg;

    localparam int ROWS      = 10;
    localparam int COLS      = 15;
    localparam int LEVEL_W   = 15;
    localparam int ROW_W     = 4;
    localparam int COL_W     = 4;
    localparam int STATUS_W  = 8;
    localparam int USED_COLS = (COLS < LEVEL_W) ? COLS : LEVEL_W;
    localparam int ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam logic [LEVEL_W-1:0] LEVEL_MASK = LEVEL_W'((64'd1 << USED_COLS) - 64'd1);

    localparam logic [STATUS_W-1:0] NOTE_ON  = 8'h90;
    localparam logic [STATUS_W-1:0] NOTE_OFF = 8'h80;

    // Write request from the top level into the row level store.
    typedef struct packed {
        logic               en;
        logic [ROW_AW-1:0]  addr;
        logic [LEVEL_W-1:0] data;
    } t_store_wr;

endpackage

FILE: src/mscm_if.sv
// Valid/ready channel interfaces for scanned rows and note events.
interface mscm_scan_if import mscm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ROW_W-1:0]   row_index;
    logic [LEVEL_W-1:0] column_levels;

    modport source (output valid, output row_index, output column_levels, input ready);
    modport sink (input valid, input row_index, input column_levels, output ready);
endinterface

interface mscm_event_if import mscm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status_byte;
    logic [ROW_W-1:0]    event_row;
    logic [COL_W-1:0]    event_column;
    logic                led_level;
    logic                last_event;

    modport source (output valid, output status_byte, output event_row,
                    output event_column, output led_level, output last_event,
                    input ready);
    modport sink (input valid, input status_byte, input event_row,
                  input event_column, input led_level, input last_event,
                  output ready);
endinterface

FILE: src/mscm_row_store.sv
// Stored column levels per row: synchronous memory with per-row valid bits and write bypass.
module mscm_row_store import mscm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [ROW_AW-1:0]  i_rd_addr,
    input  t_store_wr          i_wr,
    output logic [LEVEL_W-1:0] o_rd_data
);

    logic [LEVEL_W-1:0] r_mem [ROWS];
    logic [ROWS-1:0]    r_vld;
    logic [LEVEL_W-1:0] r_rd_data;
    logic               r_rd_vld;
    logic               bypass;

    // A write to the row being read in the same cycle is forwarded.
    assign bypass = i_wr.en && (i_wr.addr == i_rd_addr);

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (bypass) begin
            r_rd_data <= i_wr.data;
        end else begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            r_rd_vld <= bypass ? 1'b1 : r_vld[i_rd_addr];
        end
    end

    // A row never written since reset reads as all zeros.
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

FILE: src/matrix_scan_change_to_midi_top.sv
// Top level of the key matrix scanner that turns level changes into note events.
//
// Usage: each transaction on i_scan carries one scanned row, its index and the
// sampled levels of its columns. For every column whose level differs from the
// level stored for that row, one transaction leaves on o_event, in ascending
// column order: status 0x90 for a rising column and 0x80 for a falling one,
// the row and column, the activity LED level (which toggles after each event)
// and a flag that marks the last event of the row.
// The first event of a row passes through the read stage, the event serializer
// and the output register; the stored levels are read as the row is accepted.
// Throughput: at most one event per cycle, and one every cycle while changes
// are pending and the receiver is ready. The next row can wait in the read
// stage while the serializer works through the changes of the one before.
// A row index outside the matrix is accepted and dropped without effect.
// Reset clears the per-row valid bits, so all stored levels read as zero, and
// sets the LED level to one. No clearing pass is needed.
// When the receiver stalls, the event waits in the output register and the
// pipeline backs up; i_scan.ready drops only once the read stage is full.
module matrix_scan_change_to_midi_top import mscm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mscm_scan_if.sink        i_scan,
    mscm_event_if.source     o_event
);

    // Read stage: the accepted row waits here while its stored levels are read.
    logic               r_s1_valid;
    logic [ROW_W-1:0]   r_s1_row;
    logic [LEVEL_W-1:0] r_s1_levels;
    logic               r_s1_in_range;
    logic [LEVEL_W-1:0] rd_data;
    logic [ROW_AW-1:0]  rd_addr;

    // Serializer stage: remaining changed columns of one row.
    logic               r_w_valid;
    logic [ROW_W-1:0]   r_w_row;
    logic [LEVEL_W-1:0] r_w_levels;
    logic [LEVEL_W-1:0] r_w_diff;
    logic [LEVEL_W-1:0] n_w_diff;

    // Output register.
    logic                r_o_valid;
    logic [STATUS_W-1:0] r_o_status;
    logic [ROW_W-1:0]    r_o_row;
    logic [COL_W-1:0]    r_o_col;
    logic                r_o_led;
    logic                r_o_last;

    logic                r_led;

    logic               in_accept;
    logic               s1_move;
    logic               o_free;
    logic               emit;
    logic               w_done;
    logic [COL_W-1:0]   first_col;
    logic [LEVEL_W-1:0] diff;
    t_store_wr          store_wr;

    assign o_free    = !r_o_valid || o_event.ready;
    assign emit      = r_w_valid && o_free;
    assign w_done    = emit && (n_w_diff == '0);
    assign s1_move   = r_s1_valid && (!r_w_valid || w_done);
    assign i_scan.ready = !r_s1_valid || s1_move;
    assign in_accept = i_scan.valid && i_scan.ready;

    // Changed columns of the row in the read stage.
    assign diff = (r_s1_levels ^ rd_data) & LEVEL_MASK;

    // The new levels are written back as the row leaves the read stage.
    always_comb begin
        store_wr.en   = s1_move && r_s1_in_range;
        store_wr.addr = ROW_AW'(r_s1_row);
        store_wr.data = r_s1_levels;
    end

    // A row held in the read stage keeps reading its own entry, so the read data
    // stays valid however long the serializer keeps it waiting.
    assign rd_addr = in_accept ? ROW_AW'(i_scan.row_index) : ROW_AW'(r_s1_row);

    mscm_row_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .i_wr      (store_wr),
        .o_rd_data (rd_data)
    );

    // Lowest changed column still pending, and the pending set without it.
    always_comb begin
        first_col = '0;
        for (int c = USED_COLS - 1; c >= 0; c--) begin
            if (r_w_diff[c]) begin
                first_col = COL_W'(c);
            end
        end
        n_w_diff = r_w_diff & ~(LEVEL_W'(1) << first_col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_w_valid  <= 1'b0;
            r_o_valid  <= 1'b0;
            r_led      <= 1'b1;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_move) begin
                r_w_valid <= r_s1_in_range && (diff != '0);
            end else if (w_done) begin
                r_w_valid <= 1'b0;
            end

            if (emit) begin
                r_o_valid <= 1'b1;
                r_led     <= ~r_led;
            end else if (o_event.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_row      <= i_scan.row_index;
            r_s1_levels   <= i_scan.column_levels & LEVEL_MASK;
            r_s1_in_range <= (int'(i_scan.row_index) < ROWS);
        end
        if (s1_move) begin
            r_w_row    <= r_s1_row;
            r_w_levels <= r_s1_levels;
            r_w_diff   <= diff;
        end else if (emit) begin
            r_w_diff <= n_w_diff;
        end
        if (emit) begin
            r_o_status <= r_w_levels[first_col] ? NOTE_ON : NOTE_OFF;
            r_o_row    <= r_w_row;
            r_o_col    <= first_col;
            r_o_led    <= r_led;
            r_o_last   <= (n_w_diff == '0);
        end
    end

    assign o_event.valid        = r_o_valid;
    assign o_event.status_byte  = r_o_status;
    assign o_event.event_row    = r_o_row;
    assign o_event.event_column = r_o_col;
    assign o_event.led_level    = r_o_led;
    assign o_event.last_event   = r_o_last;

    // The serializer never holds a row without pending changes.
    a_work_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_w_valid |-> (r_w_diff != '0))
        else $error("serializer holds a row with no changed columns");

    // A new row enters the serializer only when the previous one finishes.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && r_w_valid) |-> w_done)
        else $error("row loaded over an unfinished row");

    // An event that is not the last keeps the serializer busy.
    a_more_events: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && (n_w_diff != '0)) |=> r_w_valid)
        else $error("serializer dropped pending columns");

    // The LED level toggles exactly with each emitted event.
    a_led_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_led == ($past(r_led) ^ $past(emit))))
        else $error("activity LED level out of step with events");

endmodule
